### design/hsv_to_rgb_converter_macros.svh
// assertion macros for the hsv to rgb converter
// depends on a clock named clock and an active high reset named reset in the caller
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
`define HSV_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hsv_to_rgb_converter assertion failed");
`define HSV_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hsv_to_rgb_converter assertion failed");
`else
`define HSV_ASSERT(label, prop)
`define HSV_ASSERT_ALWAYS(label, prop)
`endif
`endif

### design/hsv2rgb_pkg.sv
// shared widths, constants and types for the hsv to rgb converter
// no dependencies
`timescale 1ns / 1ps
package hsv2rgb_pkg;

   localparam int CHANNEL_BITS   = 8;
   localparam int HUE_W          = 14;
   localparam int HUE_U_W        = HUE_W - 1;
   localparam int FRAC_W         = 9;
   localparam int FRAC_ONE_SHIFT = 8;
   localparam int COLOR_W        = 24;

   localparam int SECTOR_STEPS = 960;
   localparam int FULL_TURN    = 5760;
   localparam int NUM_SECTORS  = FULL_TURN / SECTOR_STEPS;
   // 960 = 1024 - 64
   localparam int MUL_HI_SHIFT = 10;
   localparam int MUL_LO_SHIFT = 6;

   localparam int POS_W = 10;
   localparam int CV_W  = 2 * FRAC_W;
   localparam int CVF_W = CV_W + POS_W;
   localparam int X_W   = 30;
   localparam int XPOS_W = 27;

   // scale 65536 * 960 = 2^22 * 15
   localparam int PRE_SHIFT = 22;
   localparam int DIV_ODD   = 15;
   localparam int PROD_W    = XPOS_W + CHANNEL_BITS;
   localparam int T_W       = PROD_W - PRE_SHIFT;
   localparam int CHAN_MAX  = (1 << CHANNEL_BITS) - 1;
   localparam int SAT_LIMIT = DIV_ODD * (CHAN_MAX + 1);
   localparam int TC_W      = CHANNEL_BITS + 4;
   localparam int DIV_SHIFT = TC_W + 4;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + DIV_ODD - 1) / DIV_ODD;
   localparam int DIV_MULT_W = DIV_SHIFT - 3;
   localparam int DIVP_W    = TC_W + DIV_MULT_W;

   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   typedef logic signed [X_W-1:0] chan_x_type;
   typedef logic [CHANNEL_BITS-1:0] chan_q_type;

   typedef struct packed {
      logic             grey;
      sector_type       sector;
      logic [CVF_W-1:0] cvf;
      chan_x_type       min_x;
      chan_x_type       top_x;
   } sect_type;

   typedef struct packed {
      chan_x_type red;
      chan_x_type green;
      chan_x_type blue;
   } rgb_x_type;

   typedef struct packed {
      chan_q_type red;
      chan_q_type green;
      chan_q_type blue;
   } rgb_q_type;

endpackage

### design/hsv2rgb_sector.sv
// front end: hue sector decode, chroma product and sector-position product
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps
module hsv2rgb_sector import hsv2rgb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [HUE_W-1:0] hue,
   input  logic [FRAC_W-1:0]       saturation,
   input  logic [FRAC_W-1:0]       brightness,
   output logic                    out_valid,
   output sect_type                out_sect
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_grey_ff, s1_grey_in;
   sector_type        s1_sector_ff, s1_sector_in;
   logic [POS_W-1:0]  s1_pos_ff, s1_pos_in;
   logic [CV_W-1:0]   s1_cv_ff, s1_cv_in;
   logic [FRAC_W-1:0] s1_brt_ff;

   logic     s2_valid_ff;
   sect_type s2_ff, s2_in;

   // stage 1
   always_comb begin
      logic [HUE_U_W-1:0] hue_u;
      logic [2:0]         cnt;
      hue_u = hue[HUE_U_W-1:0];
      cnt   = '0;
      for (int k = 1; k < NUM_SECTORS; k++) begin
         cnt = cnt + 3'(hue_u >= HUE_U_W'(k * SECTOR_STEPS));
      end
      s1_valid_in  = in_valid;
      s1_grey_in   = $unsigned(hue) >= HUE_W'(FULL_TURN);
      s1_sector_in = sector_type'(cnt);
      s1_pos_in    = POS_W'(hue_u - HUE_U_W'(int'(cnt) * SECTOR_STEPS));
      s1_cv_in     = CV_W'(saturation) * CV_W'(brightness);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_grey_ff   <= s1_grey_in;
      s1_sector_ff <= s1_sector_in;
      s1_pos_ff    <= s1_pos_in;
      s1_cv_ff     <= s1_cv_in;
      s1_brt_ff    <= brightness;
   end

   // stage 2
   always_comb begin
      logic [POS_W-1:0] f;
      chan_x_type       v256;
      chan_x_type       m;
      f = s1_sector_ff[0] ? POS_W'(SECTOR_STEPS) - s1_pos_ff : s1_pos_ff;
      v256 = X_W'({s1_brt_ff, {FRAC_ONE_SHIFT{1'b0}}});
      m    = v256 - X_W'(s1_cv_ff);
      s2_in.grey   = s1_grey_ff;
      s2_in.sector = s1_sector_ff;
      s2_in.cvf    = CVF_W'(s1_cv_ff) * CVF_W'(f);
      s2_in.min_x  = (m <<< MUL_HI_SHIFT) - (m <<< MUL_LO_SHIFT);
      s2_in.top_x  = (v256 <<< MUL_HI_SHIFT) - (v256 <<< MUL_LO_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_sect  = s2_ff;

endmodule

### design/hsv2rgb_mix.sv
// channel ordering by sector, minimum added, grey for hue out of range
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps
module hsv2rgb_mix import hsv2rgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  sect_type  in_sect,
   output logic      out_valid,
   output rgb_x_type out_rgb
);

   logic      valid_ff;
   rgb_x_type rgb_ff, rgb_in;

   always_comb begin
      chan_x_type mid;
      chan_x_type lo;
      chan_x_type hi;
      mid = in_sect.min_x + X_W'(in_sect.cvf);
      lo  = in_sect.min_x;
      hi  = in_sect.top_x;
      if (in_sect.grey) begin
         rgb_in = '{red: lo, green: lo, blue: lo};
      end else begin
         unique case (in_sect.sector)
            SEC_RY: rgb_in = '{red: hi,  green: mid, blue: lo};
            SEC_YG: rgb_in = '{red: mid, green: hi,  blue: lo};
            SEC_GC: rgb_in = '{red: lo,  green: hi,  blue: mid};
            SEC_CB: rgb_in = '{red: lo,  green: mid, blue: hi};
            SEC_BM: rgb_in = '{red: mid, green: lo,  blue: hi};
            SEC_MR: rgb_in = '{red: hi,  green: lo,  blue: mid};
            default: rgb_in = '{red: lo, green: lo, blue: lo};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rgb_ff <= rgb_in;
   end

   assign out_valid = valid_ff;
   assign out_rgb   = rgb_ff;

endmodule

### design/hsv2rgb_quant.sv
// per-channel scaling to integer levels: multiply by full scale, divide by 2^22 * 15, saturate
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps
module hsv2rgb_quant import hsv2rgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  rgb_x_type in_rgb,
   output logic      out_valid,
   output rgb_q_type out_rgb
);

   localparam logic [CHANNEL_BITS-1:0] CHAN_MAX_V = '1;

   chan_x_type        x_lane [3];
   logic              q1_valid_ff;
   logic [PROD_W-1:0] q1_prod_ff [3];
   logic [PROD_W-1:0] q1_prod_in [3];
   logic              q2_valid_ff;
   logic              q2_sat_ff [3];
   logic              q2_sat_in [3];
   logic [DIVP_W-1:0] q2_prod_ff [3];
   logic [DIVP_W-1:0] q2_prod_in [3];
   chan_q_type        q_lane [3];

   assign x_lane[0] = in_rgb.red;
   assign x_lane[1] = in_rgb.green;
   assign x_lane[2] = in_rgb.blue;

   // negative or zero maps to zero
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (x_lane[l][X_W-1] || x_lane[l] == '0) begin
            q1_prod_in[l] = '0;
         end else begin
            q1_prod_in[l] = PROD_W'(x_lane[l][XPOS_W-1:0]) * PROD_W'(CHAN_MAX_V);
         end
      end
   end

   always_comb begin
      logic [T_W-1:0]  t;
      logic [TC_W-1:0] tc;
      for (int l = 0; l < 3; l++) begin
         t  = q1_prod_ff[l][PRE_SHIFT +: T_W];
         q2_sat_in[l] = 32'(t) >= SAT_LIMIT;
         tc = q2_sat_in[l] ? '0 : TC_W'(t);
         q2_prod_in[l] = DIVP_W'(tc) * DIVP_W'(DIV_MULT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
      end else begin
         q1_valid_ff <= in_valid;
         q2_valid_ff <= q1_valid_ff;
      end
      for (int l = 0; l < 3; l++) begin
         q1_prod_ff[l] <= q1_prod_in[l];
         q2_sat_ff[l]  <= q2_sat_in[l];
         q2_prod_ff[l] <= q2_prod_in[l];
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         q_lane[l] = q2_sat_ff[l] ? CHAN_MAX_V : q2_prod_ff[l][DIV_SHIFT +: CHANNEL_BITS];
      end
   end

   assign out_valid = q2_valid_ff;
   assign out_rgb   = '{red: q_lane[0], green: q_lane[1], blue: q_lane[2]};

endmodule

### design/hsv_to_rgb_converter.sv
// hsv to rgb converter top level, six register stages, no stall
// an accepted beat passes the sector, mix, quant and output registers in that order before it shows on rsp_valid
// throughput: one beat per cycle, busy is low except while reset is high
// reset: synchronous active high, clears the valid bits of every stage
// depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_mix, hsv2rgb_quant
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [HUE_W-1:0] req_hue,
   input  logic [FRAC_W-1:0]       req_saturation,
   input  logic [FRAC_W-1:0]       req_brightness,
   output logic                    rsp_valid,
   output logic [COLOR_W-1:0]      rsp_packed_color
);

   logic      accept;
   logic      sect_valid;
   sect_type  sect;
   logic      mix_valid;
   rgb_x_type mix_rgb;
   logic      quant_valid;
   rgb_q_type quant_rgb;

   logic       rsp_valid_ff;
   chan_q_type red_ff, green_ff, blue_ff;
   logic [3*CHANNEL_BITS+COLOR_W-1:0] pack_wide;

   assign busy   = reset;
   assign accept = start && !busy;

   hsv2rgb_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (sect_valid),
      .out_sect   (sect)
   );

   hsv2rgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sect_valid),
      .in_sect   (sect),
      .out_valid (mix_valid),
      .out_rgb   (mix_rgb)
   );

   hsv2rgb_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_rgb    (mix_rgb),
      .out_valid (quant_valid),
      .out_rgb   (quant_rgb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= quant_valid;
      end
      red_ff   <= quant_rgb.red;
      green_ff <= quant_rgb.green;
      blue_ff  <= quant_rgb.blue;
   end

   assign pack_wide        = {{COLOR_W{1'b0}}, red_ff, green_ff, blue_ff};
   assign rsp_packed_color = pack_wide[COLOR_W-1:0];
   assign rsp_valid        = rsp_valid_ff;

   `HSV_ASSERT(a_beat_delivered, accept |-> ##6 rsp_valid)
   `HSV_ASSERT(a_no_spurious_beat, rsp_valid |-> $past(accept, 6))
   `HSV_ASSERT(a_zero_sat_grey, rsp_valid && $past(req_saturation == '0, 6) |-> red_ff == green_ff && green_ff == blue_ff)

endmodule
